FILE: rtl/core/rgb_rle_pkg.sv
`default_nettype none

package rgb_rle_pkg;

   // packet header is this base plus the run length
   localparam logic [7:0] HDR_BASE      = 8'd127;
   // longest run a single packet can describe
   localparam logic [7:0] RUN_LIMIT     = 8'd128;
   localparam logic [7:0] MAX_RUN_RESET = 8'd127;

   // output queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_LW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic       last_pixel;
   } req_word_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic [7:0] run_blue;
      logic [7:0] run_green;
      logic [7:0] run_red;
      logic       final_packet;
   } rsp_word_type;

   // up to two packets produced by one pixel, in order
   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_word_type first_word;
      rsp_word_type second_word;
   } push_type;

   // clamp the programmed limit into 1..128
   function automatic logic [7:0] eff_max(input logic [7:0] value);
      logic [7:0] result;
      if (value == 8'd0) begin
         result = 8'd1;
      end else if (value > RUN_LIMIT) begin
         result = RUN_LIMIT;
      end else begin
         result = value;
      end
      return result;
   endfunction

   // colour packed red 23..16, green 15..8, blue 7..0
   function automatic rsp_word_type make_word(input logic [7:0]  count,
                                              input logic [23:0] colour,
                                              input logic        fin);
      rsp_word_type word;
      word.header_byte  = HDR_BASE + count;
      word.run_blue     = colour[7:0];
      word.run_green    = colour[15:8];
      word.run_red      = colour[23:16];
      word.final_packet = fin;
      return word;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rgb_rle_core.sv
`default_nettype none

module rgb_rle_core
   import rgb_rle_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         go,
   input  wire req_word_type pixel,
   input  wire logic [7:0]   run_max,
   output push_type          push
);

   logic [23:0] colour_ff, colour_in;
   logic [7:0]  count_ff, count_in;
   logic [23:0] pix;
   logic        extend;

   assign pix    = {pixel.pixel_red, pixel.pixel_green, pixel.pixel_blue};
   assign extend = (pix == colour_ff) && (count_ff < run_max);

   always_comb begin
      colour_in         = colour_ff;
      count_in          = count_ff;
      push.first_valid  = 1'b0;
      push.second_valid = 1'b0;
      push.first_word   = make_word(8'd1, pix, 1'b1);
      push.second_word  = make_word(8'd1, pix, 1'b1);
      if (count_ff == 8'd0) begin
         // no open run: the pixel opens one
         colour_in        = pix;
         count_in         = pixel.last_pixel ? 8'd0 : 8'd1;
         push.first_valid = pixel.last_pixel;
      end else if (extend) begin
         count_in         = pixel.last_pixel ? 8'd0 : count_ff + 8'd1;
         push.first_valid = pixel.last_pixel;
         push.first_word  = make_word(count_ff + 8'd1, colour_ff, 1'b1);
      end else begin
         // close the run, the pixel opens a new one
         push.first_valid  = 1'b1;
         push.first_word   = make_word(count_ff, colour_ff, 1'b0);
         push.second_valid = pixel.last_pixel;
         colour_in         = pix;
         count_in          = pixel.last_pixel ? 8'd0 : 8'd1;
      end
      if (!go) begin
         push.first_valid  = 1'b0;
         push.second_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff <= '0;
         count_ff  <= '0;
      end else if (go) begin
         colour_ff <= colour_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rgb_rle_queue.sv
`default_nettype none

module rgb_rle_queue
   import rgb_rle_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire push_type            push,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_word_type             rsp_data,
   output logic [QUEUE_LW-1:0]      level
);

   rsp_word_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LW-1:0]       level_ff, level_in;
   logic [QUEUE_AW-1:0]       wr_next;
   logic                      pop;
   logic [QUEUE_LW-1:0]       n_push;

   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_next   = wr_ptr_ff + QUEUE_AW'(1);
   assign n_push    = QUEUE_LW'(push.first_valid) + QUEUE_LW'(push.second_valid);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push[QUEUE_AW-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      level_in  = level_ff + n_push - QUEUE_LW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wr_ptr_ff] <= push.first_word;
      end
      if (push.second_valid) begin
         mem_ff[wr_next] <= push.second_word;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rgb_pixel_run_length_encoder.sv
`default_nettype none
// a taken pixel waits in the input register until the queue has room, then its packets
// are registered into the output queue and shown on rsp; one pixel per cycle while the
// queue has room; the closing pixel of an image may push two packets into the four-word
// output queue, and req_stall holds while a pixel is held and three or more words are
// queued; reset (synchronous, active high) empties the queue, closes any open run and sets
// max_run back to 127

module rgb_pixel_run_length_encoder
   import rgb_rle_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // pixel input
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   // packet output
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data,
   // max_run register
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_data
);

   // input register
   req_word_type          in_ff;
   logic                  in_vld_ff;
   // programmed limit
   logic [7:0]            max_run_ff;
   // encoder controls
   logic                  room;
   logic                  go;
   logic                  take;
   push_type              push;
   logic [QUEUE_LW-1:0]   level;

   // writes land at any time; software must change it only while the block is idle, unenforced here
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff <= MAX_RUN_RESET;
      end else if (csr_valid && csr_ready) begin
         max_run_ff <= csr_data;
      end
   end

   // the encoder fires only if the queue can take two words, the worst case
   assign room      = (level <= QUEUE_LW'(QUEUE_DEPTH - 2));
   assign go        = in_vld_ff && room;
   // the input register frees up when it fires, so a new word can follow every cycle while the queue has room
   assign req_stall = in_vld_ff && !room;
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (take) begin
         in_vld_ff <= 1'b1;
      end else if (go) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff <= req_data;
      end
   end

   // run tracking and packet building
   rgb_rle_core u_core (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .pixel   (in_ff),
      .run_max (eff_max(max_run_ff)),
      .push    (push)
   );

   // output queue, parts the two handshakes
   rgb_rle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .level     (level)
   );

   // queue never overfills
   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      level <= QUEUE_LW'(QUEUE_DEPTH))
      else $error("output queue overflow");

   // a second packet only comes with a first, and only on the closing pixel
   a_second_push : assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> (push.first_valid && go && in_ff.last_pixel))
      else $error("second packet without closing pixel");

   // every pushed packet describes a run of at least one pixel
   a_header_range : assert property (@(posedge clock) disable iff (reset)
      push.first_valid |-> push.first_word.header_byte[7])
      else $error("run packet header below 128");

   // the encoder never fires without a held pixel
   a_go_needs_word : assert property (@(posedge clock) disable iff (reset)
      (push.first_valid || push.second_valid) |-> in_vld_ff)
      else $error("packet pushed without input word");

endmodule

`default_nettype wire
